>>> rtl/planar_shadow_matrix_macros.svh
// ----------------------------------------------------------------------------
// planar_shadow_matrix assertion macros
// Concurrent checks clocked on clk, masked while rst is high.
// ----------------------------------------------------------------------------
`ifndef PLANAR_SHADOW_MATRIX_MACROS_SVH
`define PLANAR_SHADOW_MATRIX_MACROS_SVH

// implication checked every cycle outside reset
`define PSM_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// invariant checked every cycle outside reset
`define PSM_INVARIANT(lbl, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (expr)) else $error(msg);

`endif

>>> rtl/psm_pkg.sv
// ----------------------------------------------------------------------------
// psm_pkg
// Shared types, constants and helpers for the planar shadow matrix block.
// ----------------------------------------------------------------------------
`default_nettype none

package psm_pkg;

  localparam int FRAC_BITS = 16;
  localparam int DATA_W    = 32;
  localparam int REG_IDX_W = 3;

  typedef logic signed [DATA_W-1:0] q_t;

  localparam q_t ONE_Q = q_t'(64'd1 << FRAC_BITS);

  typedef enum logic [REG_IDX_W-1:0] {
    REG_LIGHT_X = 3'd0,
    REG_LIGHT_Y = 3'd1,
    REG_LIGHT_Z = 3'd2,
    REG_LIGHT_W = 3'd3
  } reg_idx_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] p0_x;
    logic signed [DATA_W-1:0] p0_y;
    logic signed [DATA_W-1:0] p0_z;
    logic signed [DATA_W-1:0] p1_x;
    logic signed [DATA_W-1:0] p1_y;
    logic signed [DATA_W-1:0] p1_z;
    logic signed [DATA_W-1:0] p2_x;
    logic signed [DATA_W-1:0] p2_y;
    logic signed [DATA_W-1:0] p2_z;
  } tri_item_t;

  typedef struct packed {
    logic [1:0]               row_index;
    logic signed [DATA_W-1:0] entry_0;
    logic signed [DATA_W-1:0] entry_1;
    logic signed [DATA_W-1:0] entry_2;
    logic signed [DATA_W-1:0] entry_3;
    logic                     last_row;
  } row_item_t;

  // plane handed from front to back: unit normal and offset
  typedef struct packed {
    logic signed [DATA_W-1:0] nx;
    logic signed [DATA_W-1:0] ny;
    logic signed [DATA_W-1:0] nz;
    logic signed [DATA_W-1:0] d;
  } plane_t;

  function automatic q_t sat32(input logic signed [63:0] v);
    q_t r;
    if (v > 64'sd2147483647) begin
      r = 32'sh7fffffff;
    end else if (v < -64'sd2147483648) begin
      r = 32'sh80000000;
    end else begin
      r = v[DATA_W-1:0];
    end
    return r;
  endfunction

endpackage

`default_nettype wire

>>> rtl/psm_queue.sv
// ----------------------------------------------------------------------------
// psm_queue
// Two-entry plane queue between the front sequencer and the row generator.
// ----------------------------------------------------------------------------
`default_nettype none

module psm_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  psm_pkg::plane_t push_data,
  output logic            full,
  input  logic            pop,
  output psm_pkg::plane_t pop_data,
  output logic            empty
);
  import psm_pkg::*;

  plane_t     mem [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;

  assign full     = (count == 2'd2);
  assign empty    = (count == 2'd0);
  assign pop_data = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop)  rd_ptr <= ~rd_ptr;
      case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule

`default_nettype wire

>>> rtl/psm_front.sv
// ----------------------------------------------------------------------------
// psm_front
// Takes triangles, forms edges, cross product, unit normal and plane offset
// with one shared multiplier, an iterative root and an iterative divider.
// ----------------------------------------------------------------------------
`default_nettype none

module psm_front (
  input  logic              clk,
  input  logic              rst,
  input  logic              tri_valid,
  output logic              tri_stall,
  input  psm_pkg::tri_item_t tri_data,
  output logic              q_push,
  output psm_pkg::plane_t   q_data,
  input  logic              q_full
);
  import psm_pkg::*;

  localparam int MAG_W  = 64;
  localparam int NORM_W = 30;
  localparam int SUM_W  = 2 * NORM_W + 2;
  localparam int ROOT_W = SUM_W + 1;
  localparam int LEN_W  = NORM_W + 1;
  localparam int NUM_W  = NORM_W + FRAC_BITS + 1;
  localparam int QUO_W  = FRAC_BITS + 2;
  localparam int DSH_W  = LEN_W + QUO_W - 1;
  localparam int ACC_W  = DATA_W + 4;

  typedef enum logic [3:0] {
    F_IDLE, F_CROSS, F_NORM, F_SQ, F_SQRT, F_DLOAD, F_DIV, F_OFS, F_PUSH
  } fstate_t;

  fstate_t              state;
  logic                 hold_valid;
  tri_item_t            hold;
  logic [4:0]           cnt;
  logic [1:0]           k;
  q_t                   e1 [3];
  q_t                   e2 [3];
  q_t                   p2 [3];
  logic signed [64:0]   cacc;
  logic [MAG_W-1:0]     mag [3];
  logic                 neg [3];
  logic [SUM_W-1:0]     sum;
  logic [ROOT_W-1:0]    rem_s;
  logic [ROOT_W-1:0]    res_s;
  logic [ROOT_W-1:0]    bitv;
  logic [LEN_W-1:0]     len;
  logic [NUM_W-1:0]     drem;
  logic [DSH_W-1:0]     dsh;
  logic [QUO_W-1:0]     quo;
  q_t                   n [3];
  logic signed [ACC_W-1:0] acc;
  q_t                   d;

  q_t                   mul_a;
  q_t                   mul_b;
  logic signed [63:0]   mul_p;
  logic signed [64:0]   cval;
  logic [MAG_W-1:0]     big;
  logic [ROOT_W-1:0]    trial;
  logic                 root_ge;
  logic [ROOT_W-1:0]    res_next;
  logic                 div_ge;
  logic [QUO_W-1:0]     quo_next;
  q_t                   quo_q;
  logic signed [ACC_W-1:0] acc_next;

  assign tri_stall = hold_valid;
  assign q_push    = (state == F_PUSH) && !q_full;
  assign q_data    = '{nx: n[0], ny: n[1], nz: n[2], d: d};

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state)
      F_CROSS: begin
        case (cnt[2:0])
          3'd0:    begin mul_a = e1[1]; mul_b = e2[2]; end
          3'd1:    begin mul_a = e1[2]; mul_b = e2[1]; end
          3'd2:    begin mul_a = e1[2]; mul_b = e2[0]; end
          3'd3:    begin mul_a = e1[0]; mul_b = e2[2]; end
          3'd4:    begin mul_a = e1[0]; mul_b = e2[1]; end
          default: begin mul_a = e1[1]; mul_b = e2[0]; end
        endcase
      end
      F_SQ: begin
        mul_a = q_t'({2'b00, mag[k][NORM_W-1:0]});
        mul_b = q_t'({2'b00, mag[k][NORM_W-1:0]});
      end
      F_OFS: begin
        mul_a = n[k];
        mul_b = p2[k];
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign mul_p = mul_a * mul_b;
  assign cval  = cacc - 65'(mul_p);

  always_comb begin
    big = mag[0];
    if (mag[1] > big) big = mag[1];
    if (mag[2] > big) big = mag[2];
  end

  // restoring square root, one result bit per cycle
  assign trial    = res_s + bitv;
  assign root_ge  = (rem_s >= trial);
  assign res_next = root_ge ? ((res_s >> 1) + bitv) : (res_s >> 1);

  // restoring divide, one quotient bit per cycle
  assign div_ge   = (DSH_W'(drem) >= dsh);
  assign quo_next = {quo[QUO_W-2:0], div_ge};
  assign quo_q    = q_t'(quo_next);

  assign acc_next = acc + ACC_W'(mul_p >>> FRAC_BITS);

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= F_IDLE;
      hold_valid <= 1'b0;
    end else begin
      if (tri_valid && !hold_valid) begin
        hold_valid <= 1'b1;
      end else if (state == F_IDLE && hold_valid) begin
        hold_valid <= 1'b0;
      end

      case (state)
        F_IDLE: begin
          if (hold_valid) begin
            state <= F_CROSS;
          end
        end
        F_CROSS: begin
          if (cnt[2:0] == 3'd5) state <= F_NORM;
        end
        F_NORM: begin
          if (big == '0) begin
            state <= F_OFS;
          end else if (big[MAG_W-1:37] == '0 && big[MAG_W-1:NORM_W] == '0 &&
                       big[NORM_W-1:21] != '0 && big[NORM_W-1]) begin
            state <= F_SQ;
          end
        end
        F_SQ: begin
          if (k == 2'd2) state <= F_SQRT;
        end
        F_SQRT: begin
          if (bitv[0]) state <= F_DLOAD;
        end
        F_DLOAD: begin
          state <= F_DIV;
        end
        F_DIV: begin
          if (cnt == '0) state <= (k == 2'd2) ? F_OFS : F_DLOAD;
        end
        F_OFS: begin
          if (k == 2'd2) state <= F_PUSH;
        end
        F_PUSH: begin
          if (!q_full) state <= F_IDLE;
        end
        default: state <= F_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (tri_valid && !hold_valid) begin
      hold <= tri_data;
    end
    case (state)
      F_IDLE: begin
        e1[0] <= sat32(64'(hold.p0_x) - 64'(hold.p1_x));
        e1[1] <= sat32(64'(hold.p0_y) - 64'(hold.p1_y));
        e1[2] <= sat32(64'(hold.p0_z) - 64'(hold.p1_z));
        e2[0] <= sat32(64'(hold.p1_x) - 64'(hold.p2_x));
        e2[1] <= sat32(64'(hold.p1_y) - 64'(hold.p2_y));
        e2[2] <= sat32(64'(hold.p1_z) - 64'(hold.p2_z));
        p2[0] <= hold.p2_x;
        p2[1] <= hold.p2_y;
        p2[2] <= hold.p2_z;
        cnt   <= '0;
      end
      F_CROSS: begin
        if (!cnt[0]) begin
          cacc <= 65'(mul_p);
        end else begin
          mag[cnt[2:1]] <= cval[64] ? MAG_W'(-cval) : cval[MAG_W-1:0];
          neg[cnt[2:1]] <= cval[64];
        end
        cnt <= cnt + 5'd1;
      end
      F_NORM: begin
        k   <= '0;
        sum <= '0;
        acc <= '0;
        if (big == '0) begin
          // degenerate triangle: zero normal, zero offset
          n[0] <= '0;
          n[1] <= '0;
          n[2] <= '0;
        end else if (big[MAG_W-1:37] != '0) begin
          for (int i = 0; i < 3; i++) mag[i] <= mag[i] >> 8;
        end else if (big[MAG_W-1:NORM_W] != '0) begin
          for (int i = 0; i < 3; i++) mag[i] <= mag[i] >> 1;
        end else if (big[NORM_W-1:21] == '0) begin
          for (int i = 0; i < 3; i++) mag[i] <= mag[i] << 8;
        end else if (!big[NORM_W-1]) begin
          for (int i = 0; i < 3; i++) mag[i] <= mag[i] << 1;
        end
      end
      F_SQ: begin
        sum <= sum + SUM_W'(mul_p);
        k   <= k + 2'd1;
        if (k == 2'd2) begin
          rem_s <= ROOT_W'(sum) + ROOT_W'(mul_p);
          res_s <= '0;
          bitv  <= ROOT_W'(1) << (ROOT_W - 1);
        end
      end
      F_SQRT: begin
        if (root_ge) rem_s <= rem_s - trial;
        res_s <= res_next;
        bitv  <= bitv >> 2;
        if (bitv[0]) begin
          len <= res_next[LEN_W-1:0];
          k   <= '0;
        end
      end
      F_DLOAD: begin
        drem <= (NUM_W'(mag[k][NORM_W-1:0]) << FRAC_BITS) + NUM_W'(len >> 1);
        dsh  <= DSH_W'(len) << (QUO_W - 1);
        quo  <= '0;
        cnt  <= 5'(QUO_W - 1);
      end
      F_DIV: begin
        if (div_ge) drem <= drem - dsh[NUM_W-1:0];
        dsh <= dsh >> 1;
        quo <= quo_next;
        cnt <= cnt - 5'd1;
        if (cnt == '0) begin
          n[k] <= neg[k] ? -quo_q : quo_q;
          k    <= (k == 2'd2) ? 2'd0 : k + 2'd1;
          acc  <= '0;
        end
      end
      F_OFS: begin
        acc <= acc_next;
        k   <= k + 2'd1;
        if (k == 2'd2) begin
          d <= sat32(-64'(acc_next));
        end
      end
      default: begin
      end
    endcase
  end

endmodule

`default_nettype wire

>>> rtl/psm_back.sv
// ----------------------------------------------------------------------------
// psm_back
// Pops a plane, forms the light dot product and emits the four matrix rows
// through an output register.
// ----------------------------------------------------------------------------
`default_nettype none

module psm_back (
  input  logic               clk,
  input  logic               rst,
  input  psm_pkg::q_t        light [4],
  input  logic               q_empty,
  output logic               q_pop,
  input  psm_pkg::plane_t    q_data,
  output logic               row_valid,
  input  logic               row_stall,
  output psm_pkg::row_item_t row_data
);
  import psm_pkg::*;

  localparam int SUM_W = 2 * DATA_W - FRAC_BITS + 2;

  typedef enum logic [2:0] {B_IDLE, B_DMUL, B_DSUM, B_RMUL, B_ROUT} bstate_t;

  bstate_t            state;
  q_t                 pl [4];
  logic signed [63:0] prod [4];
  q_t                 dot;
  logic [1:0]         row;

  q_t                 mul_b [4];
  logic signed [SUM_W-1:0] dsum;
  q_t                 ent [4];
  logic               out_load;

  assign q_pop    = (state == B_IDLE) && !q_empty;
  assign out_load = !row_valid || !row_stall;

  always_comb begin
    dsum = '0;
    for (int j = 0; j < 4; j++) begin
      mul_b[j] = (state == B_DMUL) ? pl[j] : pl[row];
      dsum     = dsum + SUM_W'(prod[j] >>> FRAC_BITS);
      ent[j]   = sat32(64'((row == 2'(j)) ? dot : q_t'(0)) - (prod[j] >>> FRAC_BITS));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= B_IDLE;
      row_valid <= 1'b0;
    end else begin
      case (state)
        B_IDLE:  if (!q_empty) state <= B_DMUL;
        B_DMUL:  state <= B_DSUM;
        B_DSUM:  state <= B_RMUL;
        B_RMUL:  state <= B_ROUT;
        B_ROUT:  if (out_load) state <= (row == 2'd3) ? B_IDLE : B_RMUL;
        default: state <= B_IDLE;
      endcase
      if (state == B_ROUT && out_load) begin
        row_valid <= 1'b1;
      end else if (!row_stall) begin
        row_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      B_IDLE: begin
        pl[0] <= q_data.nx;
        pl[1] <= q_data.ny;
        pl[2] <= q_data.nz;
        pl[3] <= q_data.d;
        row   <= '0;
      end
      B_DMUL, B_RMUL: begin
        for (int j = 0; j < 4; j++) prod[j] <= light[j] * mul_b[j];
      end
      B_DSUM: begin
        dot <= sat32(64'(dsum));
      end
      B_ROUT: begin
        if (out_load) begin
          row_data <= '{row_index: row, entry_0: ent[0], entry_1: ent[1],
                        entry_2: ent[2], entry_3: ent[3], last_row: (row == 2'd3)};
          row      <= row + 2'd1;
        end
      end
      default: begin
      end
    endcase
  end

endmodule

`default_nettype wire

>>> rtl/planar_shadow_matrix.sv
// ----------------------------------------------------------------------------
// planar_shadow_matrix
// Planar projected shadow matrix from a triangle and a light, Q16.16.
//
//   channel  dir  handshake            beat
//   tri      in   tri_valid/tri_stall  one triangle (three vertices)
//   row      out  row_valid/row_stall  one matrix row, four per triangle
//   wr       in   wr_en                light register write
//
// The front sets throughput: launch, cross product, scaling, squares, root,
// one divide per normal component, offset and push, sharing one multiplier;
// a degenerate triangle skips squares, root and divide.
// One triangle waits in the input buffer while the front is busy.
// Reset sets light to (0, 0, 0, 1.0); no memory clearing pass.
// row_stall holds the output register; plane queue, then input buffer fill up.
// ----------------------------------------------------------------------------
`default_nettype none

`include "planar_shadow_matrix_macros.svh"

module planar_shadow_matrix (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           tri_valid,
  output logic                           tri_stall,
  input  psm_pkg::tri_item_t             tri_data,
  output logic                           row_valid,
  input  logic                           row_stall,
  output psm_pkg::row_item_t             row_data,
  input  logic                           wr_en,
  input  logic [psm_pkg::REG_IDX_W-1:0]  wr_index,
  input  logic [psm_pkg::DATA_W-1:0]     wr_data
);
  import psm_pkg::*;

  q_t     light [4];
  logic   q_push;
  plane_t q_wdata;
  logic   q_full;
  logic   q_pop;
  plane_t q_rdata;
  logic   q_empty;

  always_ff @(posedge clk) begin
    if (rst) begin
      light[0] <= '0;
      light[1] <= '0;
      light[2] <= '0;
      light[3] <= ONE_Q;
    end else if (wr_en) begin
      case (wr_index)
        REG_LIGHT_X: light[0] <= wr_data;
        REG_LIGHT_Y: light[1] <= wr_data;
        REG_LIGHT_Z: light[2] <= wr_data;
        REG_LIGHT_W: light[3] <= wr_data;
        default: begin
        end
      endcase
    end
  end

  psm_front u_front (
    .clk       (clk),
    .rst       (rst),
    .tri_valid (tri_valid),
    .tri_stall (tri_stall),
    .tri_data  (tri_data),
    .q_push    (q_push),
    .q_data    (q_wdata),
    .q_full    (q_full)
  );

  psm_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_data (q_wdata),
    .full      (q_full),
    .pop       (q_pop),
    .pop_data  (q_rdata),
    .empty     (q_empty)
  );

  psm_back u_back (
    .clk       (clk),
    .rst       (rst),
    .light     (light),
    .q_empty   (q_empty),
    .q_pop     (q_pop),
    .q_data    (q_rdata),
    .row_valid (row_valid),
    .row_stall (row_stall),
    .row_data  (row_data)
  );

  `PSM_ASSERT(a_tri_buffered, (tri_valid && !tri_stall) |=> tri_stall, "tri beat not buffered")
  `PSM_INVARIANT(a_no_push_full, !(q_push && q_full), "push into full plane queue")
  `PSM_INVARIANT(a_no_pop_empty, !(q_pop && q_empty), "pop from empty plane queue")
  `PSM_ASSERT(a_last_row, row_valid |-> (row_data.last_row == (row_data.row_index == 2'd3)), "last_row mismatch")

endmodule

`default_nettype wire
